FILE: rtl/core/egg_drop_min_attempts_top_assert.svh
// Assertion macros for the egg drop solver.
// Used by egg_drop_min_attempts_top; expects clk and rst_n in scope.
`ifndef EGG_DROP_MIN_ATTEMPTS_TOP_ASSERT_SVH
`define EGG_DROP_MIN_ATTEMPTS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define EGD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define EGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/egd_pkg.sv
// Shared types and constants for the egg drop solver.
// No dependencies; used by the channel interfaces and the top level.
package egd_pkg;

  // Fixed payload widths
  localparam int EGG_W   = 4;
  localparam int FLOOR_W = 8;
  localparam int ANS_W   = 8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LAST,
    ST_FIN
  } egd_state_t;

endpackage

FILE: rtl/core/egd_in_if.sv
// Input channel of the egg drop solver: valid/ready plus one item.
// Depends on egd_pkg for the field widths.
interface egd_in_if;
  logic                          valid;
  logic                          ready;
  logic [egd_pkg::EGG_W-1:0]     egg_count;
  logic [egd_pkg::FLOOR_W-1:0]   floor_count;

  modport source (output valid, output egg_count, output floor_count, input ready);
  modport sink   (input valid, input egg_count, input floor_count, output ready);
endinterface

FILE: rtl/core/egd_out_if.sv
// Result channel of the egg drop solver: valid/ready plus one result item.
// Depends on egd_pkg for the field width.
interface egd_out_if;
  logic                        valid;
  logic                        ready;
  logic [egd_pkg::ANS_W-1:0]   min_attempts;

  modport source (output valid, output min_attempts, input ready);
  modport sink   (input valid, input min_attempts, output ready);
endinterface

FILE: rtl/core/egg_drop_min_attempts_top.sv
// Egg drop solver: table fill with one shared max/min compare unit.
// Depends on egd_pkg, egd_in_if, egd_out_if and the assertion header.
//
//  channel  | dir | payload                         | handshake
//  ---------+-----+---------------------------------+-------------
//  in_ch    | in  | egg_count[3:0], floor_count[7:0]| valid/ready
//  out_ch   | out | min_attempts[7:0]               | valid/ready
//
// One item at a time; in_ch.ready is high only while the sequencer idles.
// With E eggs and F floors (after saturation), E >= 2 and F >= 2, an item
// is worked up to the result register one k step per cycle on the table
// memory's two read ports; otherwise it goes straight to the result register.
// Synchronous active-low reset clears control only; the table needs no
// clearing pass. A result waits in out_ch until taken; the solver holds its
// last state until the output register is free.
module egg_drop_min_attempts_top #(
  parameter int MAX_EGGS   = 8,
  parameter int MAX_FLOORS = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  egd_in_if.sink           in_ch,
  egd_out_if.source        out_ch
);

  // egg and floor counters hold at least the value 2
  localparam int EGW   = (MAX_EGGS > 1) ? $clog2(MAX_EGGS + 1) : 2;
  localparam int FW    = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS + 1) : 2;
  localparam int EW    = (MAX_EGGS > 1) ? $clog2(MAX_EGGS) : 1;
  localparam int AW    = EW + FW;
  localparam int DEPTH = 1 << AW;

  // Control and datapath registers
  egd_pkg::egd_state_t state_r, state_nxt;
  logic [EGW-1:0] egg_r, egg_nxt;
  logic [EGW-1:0] e_r, e_nxt;
  logic [FW-1:0]  flr_r, flr_nxt;
  logic [FW-1:0]  f_r, f_nxt;
  logic [FW-1:0]  k_r, k_nxt;
  logic [FW-1:0]  best_r, best_nxt;
  logic [FW-1:0]  ans_r, ans_nxt;
  logic           pend_r, pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [egd_pkg::ANS_W-1:0] out_data_r, out_data_nxt;

  // Read pipeline: registered memory data plus bypass info
  logic [FW-1:0]  broke_mem_r, held_mem_r;
  logic [FW-1:0]  broke_col_r, held_col_r;
  logic           broke_dir_r, held_dir_r;

  logic [FW-1:0]  mem [DEPTH];

  // Input saturation
  logic [EGW-1:0] egg_sat;
  logic [FW-1:0]  flr_sat;

  // Shared compare unit
  logic [FW-1:0]  broke_v, held_v, worst_v, step_best;
  logic [FW-1:0]  broke_col, held_col;
  logic [AW-1:0]  broke_addr, held_addr, wr_addr;
  logic           accept, out_load;

  assign accept         = in_ch.valid && in_ch.ready;
  assign in_ch.ready    = (state_r == egd_pkg::ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.min_attempts = out_data_r;
  assign out_load       = (state_r == egd_pkg::ST_FIN) && (!out_valid_r || out_ch.ready);

  // Clamp eggs to 1..MAX_EGGS and floors to MAX_FLOORS
  always_comb begin
    int unsigned eg_i;
    int unsigned fl_i;
    eg_i = int'(in_ch.egg_count);
    fl_i = int'(in_ch.floor_count);
    if (eg_i == 0) begin
      eg_i = 1;
    end else if (eg_i > MAX_EGGS) begin
      eg_i = MAX_EGGS;
    end
    if (fl_i > MAX_FLOORS) begin
      fl_i = MAX_FLOORS;
    end
    egg_sat = EGW'(eg_i);
    flr_sat = FW'(fl_i);
  end

  // Read addresses: broke = T[e-1][k-1], held = T[e][f-k]; row index is e-1
  assign broke_col  = k_r - FW'(1);
  assign held_col   = f_r - k_r;
  assign broke_addr = {EW'(int'(e_r) - 2), broke_col};
  assign held_addr  = {EW'(int'(e_r) - 1), held_col};
  assign wr_addr    = {EW'(int'(e_r) - 1), f_r};

  // Columns 0 and 1 and the one-egg row are their column index
  assign broke_v   = broke_dir_r ? broke_col_r : broke_mem_r;
  assign held_v    = held_dir_r  ? held_col_r  : held_mem_r;
  assign worst_v   = ((broke_v > held_v) ? broke_v : held_v) + FW'(1);
  assign step_best = (worst_v < best_r) ? worst_v : best_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      egd_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ((egg_sat < EGW'(2)) || (flr_sat < FW'(2))) ?
                      egd_pkg::ST_FIN : egd_pkg::ST_RUN;
        end
      end
      egd_pkg::ST_RUN: begin
        if (k_r == f_r) begin
          state_nxt = egd_pkg::ST_LAST;
        end
      end
      egd_pkg::ST_LAST: begin
        state_nxt = ((f_r == flr_r) && (e_r == egg_r)) ? egd_pkg::ST_FIN : egd_pkg::ST_RUN;
      end
      egd_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = egd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = egd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    int unsigned ans_i;
    egg_nxt       = egg_r;
    flr_nxt       = flr_r;
    e_nxt         = e_r;
    f_nxt         = f_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    ans_nxt       = ans_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    ans_i         = int'(ans_r);
    case (state_r)
      egd_pkg::ST_IDLE: begin
        if (accept) begin
          egg_nxt  = egg_sat;
          flr_nxt  = flr_sat;
          e_nxt    = EGW'(2);
          f_nxt    = FW'(2);
          k_nxt    = FW'(1);
          best_nxt = '1;
          pend_nxt = 1'b0;
          // trivial cases: answer is the floor count
          ans_nxt  = flr_sat;
        end
      end
      egd_pkg::ST_RUN: begin
        pend_nxt = 1'b1;
        if (pend_r) begin
          best_nxt = step_best;
        end
        if (k_r != f_r) begin
          k_nxt = k_r + FW'(1);
        end
      end
      egd_pkg::ST_LAST: begin
        // step_best closes the entry; it is written to the table this cycle
        k_nxt    = FW'(1);
        best_nxt = '1;
        pend_nxt = 1'b0;
        if (f_r == flr_r) begin
          f_nxt = FW'(2);
          if (e_r == egg_r) begin
            ans_nxt = step_best;
          end else begin
            e_nxt = e_r + EGW'(1);
          end
        end else begin
          f_nxt = f_r + FW'(1);
        end
      end
      egd_pkg::ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (ans_i > 255) ? 8'hFF : egd_pkg::ANS_W'(ans_i);
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egd_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    egg_r      <= egg_nxt;
    flr_r      <= flr_nxt;
    e_r        <= e_nxt;
    f_r        <= f_nxt;
    k_r        <= k_nxt;
    best_r     <= best_nxt;
    ans_r      <= ans_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (state_r == egd_pkg::ST_LAST) begin
      mem[wr_addr] <= step_best;
    end
    broke_mem_r <= mem[broke_addr];
    held_mem_r  <= mem[held_addr];
    broke_col_r <= broke_col;
    held_col_r  <= held_col;
    broke_dir_r <= (broke_col < FW'(2)) || (e_r == EGW'(2));
    held_dir_r  <= (held_col < FW'(2));
  end

`include "egg_drop_min_attempts_top_assert.svh"

  `EGD_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after accept")
  `EGD_ASSERT_IMPL(a_k_range, state_r == egd_pkg::ST_RUN, (k_r != '0) && (k_r <= f_r), "k out of range")
  `EGD_ASSERT_IMPL(a_last_pending, state_r == egd_pkg::ST_LAST, pend_r && (k_r == f_r), "last step without data")
  `EGD_ASSERT_IMPL(a_idx_bound, (state_r == egd_pkg::ST_RUN) || (state_r == egd_pkg::ST_LAST), (e_r >= EGW'(2)) && (e_r <= egg_r) && (f_r <= flr_r), "table index beyond item")

endmodule
